/* sv/rav_pkg.sv */
// ----------------------------------------------------------------------------
// rav_pkg
// Shared types and constants of the running average filter.
// ----------------------------------------------------------------------------
package rav_pkg;

    // Width of the window size register and of the sample count.
    localparam int WIN_W        = 6;
    // Width of the configuration register index.
    localparam int CFG_IDX_W    = 2;
    // Width of the configuration write data (widest register).
    localparam int CFG_DATA_W   = WIN_W;
    // Window size after reset.
    localparam int WINDOW_RESET = 20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = CFG_IDX_W'(1);

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DIV,
        S_DONE
    } t_state;

endpackage

/* sv/rav_ifs.sv */
// ----------------------------------------------------------------------------
// rav_ifs
// Handshake channels of the running average filter: sample in, average out,
// configuration writes.
// ----------------------------------------------------------------------------
interface rav_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rav_average_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

interface rav_cfg_if
    import rav_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/rav_ram.sv */
// ----------------------------------------------------------------------------
// rav_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rav_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sv/running_average_filter.sv */
// Flow: an accepted sample passes through READ, UPDATE, DIV and DONE before its
//   average is loaded; a bypassed sample goes from IDLE straight to DONE.
// A new sample is taken only in IDLE, once the last average is in the output word;
//   the restoring divider retires one quotient bit per cycle over the sum.
// Reset: synchronous, active low; window size 20, filter enabled, history empty.
// ----------------------------------------------------------------------------
// running_average_filter
// Moving average over the most recent window_size samples, kept in a circular
// sample RAM with a running sum and divided by the samples seen so far.
// ----------------------------------------------------------------------------
module running_average_filter
    import rav_pkg::*;
#(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rav_sample_if.sink     i_sample_ch,
    rav_average_if.source  o_average_ch,
    rav_cfg_if.sink        i_cfg_ch
);

    // Sizes derived from the parameters.
    localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    // Largest window the 6-bit register can reach within the store.
    localparam int WIN_CAP = (MAX_WINDOW > 63) ? 63 : MAX_WINDOW;
    // The sum holds at most 63 full-scale samples.
    localparam int SUM_W   = SAMPLE_BITS + WIN_W;
    localparam int CNT_W   = $clog2(SUM_W);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                 r_state, n_state;
    logic [WIN_W-1:0]       r_window_size;
    logic                   r_filter_enable;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [WIN_W-1:0]       r_seen, n_seen;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SUM_W-1:0]       r_dvd;          // dividend, quotient shifts in at the bottom
    logic [WIN_W-1:0]       r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_avg;

    // Sequencer outputs.
    logic                   w_in_ready;
    logic                   w_ram_we;
    logic                   w_out_load;

    logic                   w_in_acc;
    logic                   w_cfg_acc;
    logic [WIN_W-1:0]       w_win;
    logic [SAMPLE_BITS-1:0] w_old_raw;
    logic [SAMPLE_BITS-1:0] w_old;
    logic [IDX_W:0]         w_idx_inc;

    // Divider step.
    logic [WIN_W:0]         w_trial;
    logic                   w_ge;
    logic [WIN_W:0]         w_diff;

    assign w_in_acc  = i_sample_ch.valid && w_in_ready;
    assign w_cfg_acc = i_cfg_ch.valid && i_cfg_ch.ready;

    // Writes must arrive only while idle (the block does not enforce it); the port is always open.
    assign i_cfg_ch.ready       = 1'b1;
    assign i_sample_ch.ready    = w_in_ready;
    assign o_average_ch.valid   = r_out_valid;
    assign o_average_ch.average = r_out_avg;

    // Effective window: zero acts as one, saturate at the store depth.
    always_comb begin
        if (r_window_size == '0) begin
            w_win = WIN_W'(1);
        end else if (int'(r_window_size) > WIN_CAP) begin
            w_win = WIN_W'(WIN_CAP);
        end else begin
            w_win = r_window_size;
        end
    end

    // ------------------------------------------------------------------
    // Sample store. The window only changes together with a history
    // clear, so writes fill entries 0..win-1 in order; the entry under
    // the write index holds a real sample only once the window is full.
    // ------------------------------------------------------------------
    rav_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_sample),
        .i_raddr (r_idx),
        .o_rdata (w_old_raw)
    );

    assign w_old     = (r_seen == w_win) ? w_old_raw : '0;
    assign w_idx_inc = {1'b0, r_idx} + 1'b1;

    // Running sum, write index and count advance in the update cycle.
    always_comb begin
        n_sum  = r_sum;
        n_idx  = r_idx;
        n_seen = r_seen;
        if (r_state == S_UPDATE) begin
            n_sum = r_sum - SUM_W'(w_old) + SUM_W'(r_sample);
            if (w_idx_inc == (IDX_W + 1)'(w_win)) begin
                n_idx = '0;
            end else begin
                n_idx = w_idx_inc[IDX_W-1:0];
            end
            if (r_seen < w_win) begin
                n_seen = r_seen + 1'b1;
            end
        end
    end

    // One restoring step: compare the shifted remainder with the count.
    assign w_trial = {r_rem, r_dvd[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_seen});
    assign w_diff  = w_trial - {1'b0, r_seen};

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = r_filter_enable ? S_READ : S_DONE;
                end
            end
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        w_in_ready = 1'b0;
        w_ram_we   = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE:   w_in_ready = 1'b1;
            S_UPDATE: w_ram_we   = 1'b1;
            // Hand the average over once the output word is free.
            S_DONE:   w_out_load = !r_out_valid || o_average_ch.ready;
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and filter state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_window_size   <= WIN_W'(WINDOW_RESET);
            r_filter_enable <= 1'b1;
            r_sum           <= '0;
            r_idx           <= '0;
            r_seen          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_idx   <= n_idx;
            r_seen  <= n_seen;
            if (w_cfg_acc) begin
                if (i_cfg_ch.index == REG_WINDOW_SIZE) begin
                    // Drop all history; a zero count hides the old store.
                    r_window_size <= i_cfg_ch.data;
                    r_sum         <= '0;
                    r_idx         <= '0;
                    r_seen        <= '0;
                end else if (i_cfg_ch.index == REG_FILTER_ENABLE) begin
                    r_filter_enable <= i_cfg_ch.data[0];
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_average_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath: sample, divider, output word
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample <= i_sample_ch.sample;
            // Bypass: park the sample where the quotient would end up.
            r_dvd    <= SUM_W'(i_sample_ch.sample);
        end
        if (r_state == S_UPDATE) begin
            r_dvd <= n_sum;
            r_rem <= '0;
            r_cnt <= CNT_W'(SUM_W - 1);
        end
        if (r_state == S_DIV) begin
            r_dvd <= {r_dvd[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[WIN_W-1:0] : w_trial[WIN_W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
        if (w_out_load) begin
            r_out_avg <= r_dvd[SAMPLE_BITS-1:0];
        end
    end

`ifndef SYNTHESIS
    // The count never runs past the window.
    a_seen_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= w_win)
        else $error("sample count exceeds window");

    // The sum stays below the count shifted left by SAMPLE_BITS, and is zero when empty.
    a_sum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen == '0) ? (r_sum == '0) : ((r_sum >> SAMPLE_BITS) < SUM_W'(r_seen)))
        else $error("running sum out of range");

    // A finished quotient always fits the output word.
    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> ((r_dvd >> SAMPLE_BITS) == '0))
        else $error("average overflows output word");
`endif

endmodule

/* verif/tb_running_average_filter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_average_filter
// Self-checking bench for the running average filter. A directed table covers
// reset behavior, window clamping, register writes that clear history and the
// pass-through mode. Random phases follow, each with its own enable state,
// sample mix and handshake idling, most with a new window setting. Every word
// is checked against a typed value or an in-bench model of the circular store and running sum.
// ----------------------------------------------------------------------------
module tb_running_average_filter;
    import rav_pkg::*;

    localparam int MAX_WIN      = 32;
    localparam int SAMPLE_W     = 16;
    localparam int RANDOM_ITEMS = 1880;
    // Long hold-off on the average side, long enough to back the block up.
    localparam int HOLD_CYCLES  = 300;
    // Cycles to watch for stray words once nothing is outstanding.
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_LIMIT = 10;

    // Register indexes that map to no register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    typedef enum bit {ROW_CONFIG, ROW_SAMPLE} t_row_kind;
    typedef enum int {MIX_FULL, MIX_EDGE, MIX_LOW, MIX_PEAK} t_sample_mix;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]   sample;
        bit                    typed;
        logic [SAMPLE_W-1:0]   avg;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    rav_sample_if  #(.SAMPLE_BITS(SAMPLE_W)) smp_ch ();
    rav_average_if #(.SAMPLE_BITS(SAMPLE_W)) avg_ch ();
    rav_cfg_if                               cfg_ch ();

    running_average_filter #(
        .MAX_WINDOW  (MAX_WIN),
        .SAMPLE_BITS (SAMPLE_W)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sample_ch  (smp_ch),
        .o_average_ch (avg_ch),
        .i_cfg_ch     (cfg_ch)
    );

    // Shadow of the filter: configuration plus circular store and running sum.
    logic [WIN_W-1:0]    win_reg;
    bit                  avg_enable;
    logic [SAMPLE_W-1:0] hist [MAX_WIN];
    int unsigned         hist_sum;
    int unsigned         wr_ptr;
    int unsigned         fill;

    // Averages owed by the block, oldest first.
    logic [SAMPLE_W-1:0] pending_averages [$];
    t_dir_row            dir_rows [$];

    int fault_count;
    bit src_idles;
    bit sink_idles;
    bit hold_ask;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop, far above the slowest legal run.
    initial begin
        #20_000_000;
        $display("running_average_filter regression: fail");
        $finish;
    end

    function automatic void clear_history();
        for (int i = 0; i < MAX_WIN; i++) hist[i] = '0;
        hist_sum = 0;
        wr_ptr   = 0;
        fill     = 0;
    endfunction

    // Mirror a register write; a window write wipes all history.
    function automatic void apply_register(input logic [CFG_IDX_W-1:0]  idx,
                                           input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_WINDOW_SIZE) begin
            win_reg = val[WIN_W-1:0];
            clear_history();
        end else if (idx == REG_FILTER_ENABLE) begin
            avg_enable = val[0];
        end
    endfunction

    // Push one sample through the shadow store and return the average owed.
    function automatic logic [SAMPLE_W-1:0] advance_window(input logic [SAMPLE_W-1:0] s);
        int unsigned span;
        span = (win_reg == 0) ? 1 : ((win_reg > MAX_WIN) ? MAX_WIN : win_reg);
        // Bypass leaves the store alone.
        if (!avg_enable) return s;
        if (wr_ptr >= span) wr_ptr = 0;
        // Drop the oldest sample from the sum, then add the new one.
        hist_sum     = hist_sum - hist[wr_ptr] + s;
        hist[wr_ptr] = s;
        wr_ptr++;
        if (wr_ptr >= span) wr_ptr = 0;
        if (fill < span) fill++;
        return SAMPLE_W'(hist_sum / fill);
    endfunction

    function automatic void log_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (!src_idles || r < 9) return 0;
        if (r < 14) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 15) < 12) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample(input t_sample_mix mix);
        int r;
        case (mix)
            MIX_FULL: begin
                r = $urandom_range(0, 7);
                if (r == 0) return '0;
                if (r == 1) return '1;
                return SAMPLE_W'($urandom_range(0, 65535));
            end
            MIX_EDGE: begin
                case ($urandom_range(0, 5))
                    0: return 16'd0;
                    1: return 16'd1;
                    2: return 16'd32767;
                    3: return 16'd32768;
                    4: return 16'd65534;
                    default: return 16'd65535;
                endcase
            end
            MIX_LOW: return SAMPLE_W'($urandom_range(0, 255));
            default: return '1;
        endcase
    endfunction

    function automatic void cfg_row(input logic [CFG_IDX_W-1:0]  idx,
                                    input logic [CFG_DATA_W-1:0] val);
        t_dir_row row;
        row       = '{kind: ROW_CONFIG, default: '0};
        row.idx   = idx;
        row.data  = val;
        dir_rows.push_back(row);
    endfunction

    function automatic void smp_row(input logic [SAMPLE_W-1:0] s, input bit typed,
                                    input logic [SAMPLE_W-1:0] avg);
        t_dir_row row;
        row        = '{kind: ROW_SAMPLE, default: '0};
        row.sample = s;
        row.typed  = typed;
        row.avg    = avg;
        dir_rows.push_back(row);
    endfunction

    // Offer one sample word and log what the block owes for it once accepted.
    // A typed expectation replaces the shadow's answer but the shadow still advances.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                               input logic [SAMPLE_W-1:0] typed_avg);
        int                  gap;
        logic [SAMPLE_W-1:0] due;
        gap = pick_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            smp_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= s;
        do @(posedge i_clk); while (!smp_ch.ready);
        due = advance_window(s);
        pending_averages.push_back(typed ? typed_avg : due);
    endtask

    // Write a register once the block has returned every owed average.
    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        smp_ch.valid <= 1'b0;
        while (pending_averages.size() != 0) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_register(idx, val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Average side: random stalls, plus the long hold-off on request.
    initial begin : average_sink
        int stall_left;
        stall_left   = 0;
        avg_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_ask) begin
                hold_ask   = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && sink_idles && $urandom_range(0, 7) < 2) begin
                stall_left = pick_stall();
            end
            if (stall_left > 0) begin
                stall_left--;
                avg_ch.ready <= 1'b0;
            end else begin
                avg_ch.ready <= 1'b1;
            end
        end
    end

    // Compare every accepted average word with the oldest one owed.
    always @(posedge i_clk) begin : check_average
        logic [SAMPLE_W-1:0] want;
        if (i_rst_n && avg_ch.valid && avg_ch.ready) begin
            if (pending_averages.size() == 0) begin
                log_fault($sformatf("unexpected average word %0d", avg_ch.average));
            end else begin
                want = pending_averages.pop_front();
                if (avg_ch.average !== want)
                    log_fault($sformatf("average mismatch: expected %0d, got %0d",
                                        want, avg_ch.average));
            end
        end
    end

    initial begin : stimulus
        int               sent;
        int               phase;
        int               len;
        int               r;
        logic [WIN_W-1:0] win;
        bit               en;
        t_sample_mix      mix;

        i_rst_n       = 1'b0;
        smp_ch.valid  = 1'b0;
        smp_ch.sample = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = REG_WINDOW_SIZE;
        cfg_ch.data   = '0;
        fault_count   = 0;
        src_idles     = 1'b1;
        sink_idles    = 1'b1;
        hold_ask      = 1'b0;
        win_reg       = WIN_W'(WINDOW_RESET);
        avg_enable    = 1'b1;
        clear_history();

        // Out of reset: window of 20, averaging on, empty history.
        smp_row(16'd65535, 1, 16'd65535);
        smp_row(16'd0,     1, 16'd32767);
        smp_row(16'd1,     0, '0);
        // Window of one: every sample is its own average.
        cfg_row(REG_WINDOW_SIZE, 6'd1);
        smp_row(16'd12345, 1, 16'd12345);
        smp_row(16'd0,     1, 16'd0);
        smp_row(16'd65535, 1, 16'd65535);
        // Zero window behaves as a window of one.
        cfg_row(REG_WINDOW_SIZE, 6'd0);
        smp_row(16'd777,   1, 16'd777);
        smp_row(16'd65535, 1, 16'd65535);
        // Oversized window saturates at the store depth.
        cfg_row(REG_WINDOW_SIZE, 6'd63);
        smp_row(16'd65535, 1, 16'd65535);
        smp_row(16'd65534, 0, '0);
        // Window of two: watch the index wrap and the oldest sample drop out.
        cfg_row(REG_WINDOW_SIZE, 6'd2);
        smp_row(16'd100,   1, 16'd100);
        smp_row(16'd201,   1, 16'd150);
        smp_row(16'd300,   1, 16'd250);
        smp_row(16'd0,     0, '0);
        // Bypass with history held; only bit zero of the data counts.
        cfg_row(REG_FILTER_ENABLE, 6'h3E);
        smp_row(16'd40000, 1, 16'd40000);
        smp_row(16'd65535, 1, 16'd65535);
        // Writes to unmapped indexes change nothing.
        cfg_row(REG_SPARE_2, 6'h3F);
        cfg_row(REG_SPARE_3, 6'h15);
        // Back to averaging; history from before the bypass must still count.
        cfg_row(REG_FILTER_ENABLE, 6'h3F);
        smp_row(16'd0,     0, '0);
        // Full-depth window restarts from empty.
        cfg_row(REG_WINDOW_SIZE, 6'd32);
        smp_row(16'd65535, 1, 16'd65535);
        smp_row(16'd65535, 1, 16'd65535);
        smp_row(16'd0,     1, 16'd43690);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CONFIG)
                write_register(dir_rows[i].idx, dir_rows[i].data);
            else
                send_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].avg);
        end

        // Random phases: new settings, sample mix and idling for each.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            r   = $urandom_range(0, 9);
            en  = ($urandom_range(0, 5) != 0);
            mix = t_sample_mix'($urandom_range(0, 3));
            case (r)
                0:       win = 6'd0;
                1:       win = 6'd1;
                2:       win = 6'd32;
                3:       win = WIN_W'($urandom_range(33, 63));
                4:       win = 6'd63;
                default: win = WIN_W'($urandom_range(2, 31));
            endcase
            // First two phases pin the largest sums and the long hold-off.
            if (phase == 0) begin
                win = 6'd63;
                en  = 1'b1;
                mix = MIX_PEAK;
            end else if (phase == 1) begin
                win = 6'd32;
                en  = 1'b1;
                mix = MIX_EDGE;
            end
            write_register(REG_FILTER_ENABLE,
                           {(CFG_DATA_W-1)'($urandom_range(0, 31)), en});
            if (phase < 2 || $urandom_range(0, 3) != 0)
                write_register(REG_WINDOW_SIZE, win);
            if ($urandom_range(0, 7) == 0)
                write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                               CFG_DATA_W'($urandom_range(0, 63)));

            // Phase 2 runs with no idling on either side.
            src_idles  = (phase != 2) && ($urandom_range(0, 3) != 0);
            sink_idles = (phase != 2) && ($urandom_range(0, 3) != 0);

            len = (phase == 0) ? 70 : $urandom_range(40, 200);
            for (int k = 0; k < len; k++) begin
                // Stall the average side for a long stretch while samples keep coming.
                if (k == 10 && (phase == 1 || $urandom_range(0, 5) == 0))
                    hold_ask = 1'b1;
                send_sample(draw_sample(mix), 0, '0);
                sent++;
            end
            phase++;
        end

        @(negedge i_clk);
        smp_ch.valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0)
            $display("running_average_filter regression: pass");
        else
            $display("running_average_filter regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
sv/rav_pkg.sv
sv/rav_ifs.sv
sv/rav_ram.sv
sv/running_average_filter.sv
verif/tb_running_average_filter.sv
